@@ rtl/core/afq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afq_pkg
// Shared types and constants for the aging FIFO queue: depth, widths,
// mode and status codes, and the control bundle that drives the cell chain.
// ----------------------------------------------------------------------------
package afq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // input modes
    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DEQ   = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RSVD  = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic {
        CFG_MAX_ENTRIES = 1'b0,
        CFG_MAX_DELAY   = 1'b1
    } t_cfg_idx;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_DEQ  = 1'b1
    } t_state;

    // control bundle toward the cell chain
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [IDX_W-1:0]  wr_idx;
        logic [DATA_W-1:0] handle;
        logic [DATA_W-1:0] stamp;
    } t_chain_ctl;

endpackage

@@ rtl/core/afq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afq_cell
// One queue slot: holds a handle and its arrival stamp. Loads a new entry
// or takes the entry of its upstream neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module afq_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic                       i_load,
    input  logic [afq_pkg::DATA_W-1:0] i_load_handle,
    input  logic [afq_pkg::DATA_W-1:0] i_load_stamp,
    input  logic [afq_pkg::DATA_W-1:0] i_next_handle,
    input  logic [afq_pkg::DATA_W-1:0] i_next_stamp,
    output logic [afq_pkg::DATA_W-1:0] o_handle,
    output logic [afq_pkg::DATA_W-1:0] o_stamp
);

    logic [afq_pkg::DATA_W-1:0] r_handle;
    logic [afq_pkg::DATA_W-1:0] r_stamp;

    // payload only, no reset; load and shift never coincide
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_handle <= i_load_handle;
            r_stamp  <= i_load_stamp;
        end else if (i_shift) begin
            r_handle <= i_next_handle;
            r_stamp  <= i_next_stamp;
        end
    end

    assign o_handle = r_handle;
    assign o_stamp  = r_stamp;

endmodule

@@ rtl/core/afq_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afq_chain
// Row of queue cells with the head in cell 0. A shift moves every entry one
// cell toward the head; an enqueue writes the cell just past the last entry.
// ----------------------------------------------------------------------------
module afq_chain (
    input  logic                       i_clk,
    input  afq_pkg::t_chain_ctl        i_ctl,
    output logic [afq_pkg::DATA_W-1:0] o_head_handle,
    output logic [afq_pkg::DATA_W-1:0] o_head_stamp
);

    logic [afq_pkg::DATA_W-1:0] w_handle [afq_pkg::DEPTH];
    logic [afq_pkg::DATA_W-1:0] w_stamp  [afq_pkg::DEPTH];

    genvar g;
    generate
        for (g = 0; g < afq_pkg::DEPTH; g++) begin : g_cell
            logic                       w_load;
            logic [afq_pkg::DATA_W-1:0] w_next_h;
            logic [afq_pkg::DATA_W-1:0] w_next_s;

            // write select for this slot
            assign w_load = i_ctl.load && (i_ctl.wr_idx == afq_pkg::IDX_W'(g));

            // upstream neighbor; the tail cell pulls in don't-care data
            if (g == afq_pkg::DEPTH - 1) begin : g_tail
                assign w_next_h = '0;
                assign w_next_s = '0;
            end else begin : g_mid
                assign w_next_h = w_handle[g+1];
                assign w_next_s = w_stamp[g+1];
            end

            afq_cell u_cell (
                .i_clk         (i_clk),
                .i_shift       (i_ctl.shift),
                .i_load        (w_load),
                .i_load_handle (i_ctl.handle),
                .i_load_stamp  (i_ctl.stamp),
                .i_next_handle (w_next_h),
                .i_next_stamp  (w_next_s),
                .o_handle      (w_handle[g]),
                .o_stamp       (w_stamp[g])
            );
        end
    endgenerate

    assign o_head_handle = w_handle[0];
    assign o_head_stamp  = w_stamp[0];

endmodule

@@ rtl/core/aging_fifo_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_fifo_queue_top
// Bounded FIFO of packet handles with arrival stamps; dequeue drops expired
// head entries before popping. Entries live in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Enqueue, flush and no-op: result registered in the cycle after the item is taken.
// Dequeue: the head cell is checked and expired entries are shifted out one entry per
//   cycle, then the head is popped or an empty status is returned.
// One item in flight; a new item is taken only once no result is pending or
//   in the cycle in which the pending result transfers.
// Reset (sync, active low) empties the queue and loads max_entries = 64,
//   max_delay = 1000; cell contents are not cleared.
// ----------------------------------------------------------------------------
module aging_fifo_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] handle_in, [63:32] now
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] handle_out, [38:32] dropped,
                                   // [45:39] occupancy, [47:46] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = afq_pkg::CNT_W;

    afq_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [31:0]                r_now, n_now;
    logic [6:0]                 r_dropped, n_dropped;
    logic [6:0]                 r_max_entries;
    logic [31:0]                r_max_delay;

    logic                       r_out_valid, n_out_valid;
    afq_pkg::t_status           r_out_status, n_out_status;
    logic [31:0]                r_out_handle, n_out_handle;
    logic [6:0]                 r_out_dropped, n_out_dropped;
    logic [6:0]                 r_out_occ, n_out_occ;

    afq_pkg::t_chain_ctl        w_ctl;
    logic [31:0]                w_head_handle;
    logic [31:0]                w_head_stamp;
    logic [CW-1:0]              w_limit;
    logic [31:0]                w_age;
    logic                       w_accept;
    afq_pkg::t_mode             w_mode;

    afq_chain u_chain (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .o_head_handle (w_head_handle),
        .o_head_stamp  (w_head_stamp)
    );

    // effective limit: max_entries clamped to the depth
    assign w_limit = ({25'd0, r_max_entries} > 32'(afq_pkg::DEPTH)) ?
                     CW'(afq_pkg::DEPTH) : CW'(r_max_entries);
    assign w_age    = r_now - w_head_stamp;
    assign w_mode   = afq_pkg::t_mode'(s_tuser);
    assign s_tready = (r_state == afq_pkg::S_IDLE) && (!r_out_valid || m_tready);
    assign w_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 7'd64;
            r_max_delay   <= 32'd1000;
        end else if (i_cfg_we) begin
            case (afq_pkg::t_cfg_idx'(i_cfg_idx))
                afq_pkg::CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[6:0];
                afq_pkg::CFG_MAX_DELAY:   r_max_delay   <= i_cfg_data;
                default:                  r_max_entries <= r_max_entries;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= afq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now         <= n_now;
        r_dropped     <= n_dropped;
        r_out_status  <= n_out_status;
        r_out_handle  <= n_out_handle;
        r_out_dropped <= n_out_dropped;
        r_out_occ     <= n_out_occ;
    end

    // next state, chain control and result
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_now         = r_now;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid && !m_tready;
        n_out_status  = r_out_status;
        n_out_handle  = r_out_handle;
        n_out_dropped = r_out_dropped;
        n_out_occ     = r_out_occ;
        w_ctl.shift   = 1'b0;
        w_ctl.load    = 1'b0;
        w_ctl.wr_idx  = r_count[afq_pkg::IDX_W-1:0];
        w_ctl.handle  = s_tdata[31:0];
        w_ctl.stamp   = s_tdata[63:32];

        case (r_state)
            afq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_status  = afq_pkg::STAT_OK;
                    n_out_handle  = '0;
                    n_out_dropped = '0;
                    n_out_occ     = 7'(r_count);
                    case (w_mode)
                        afq_pkg::MODE_ENQ: begin
                            n_out_valid = 1'b1;
                            if (r_count >= w_limit) begin
                                n_out_status = afq_pkg::STAT_FULL;
                            end else begin
                                w_ctl.load = 1'b1;
                                n_count    = r_count + CW'(1);
                                n_out_occ  = 7'(r_count + CW'(1));
                            end
                        end
                        afq_pkg::MODE_DEQ: begin
                            n_now     = s_tdata[63:32];
                            n_dropped = '0;
                            n_state   = afq_pkg::S_DEQ;
                        end
                        afq_pkg::MODE_FLUSH: begin
                            n_out_valid = 1'b1;
                            n_count     = '0;
                            n_out_occ   = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            afq_pkg::S_DEQ: begin
                // one head check per cycle: empty, expired, or pop
                if (r_count == '0) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = afq_pkg::STAT_EMPTY;
                    n_out_handle  = '0;
                    n_out_dropped = r_dropped;
                    n_out_occ     = '0;
                    n_state       = afq_pkg::S_IDLE;
                end else if (w_age >= r_max_delay) begin
                    w_ctl.shift = 1'b1;
                    n_count     = r_count - CW'(1);
                    n_dropped   = r_dropped + 7'd1;
                end else begin
                    w_ctl.shift   = 1'b1;
                    n_count       = r_count - CW'(1);
                    n_out_valid   = 1'b1;
                    n_out_status  = afq_pkg::STAT_OK;
                    n_out_handle  = w_head_handle;
                    n_out_dropped = r_dropped;
                    n_out_occ     = 7'(r_count - CW'(1));
                    n_state       = afq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = afq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {2'b00, r_out_occ, r_out_dropped, r_out_handle};

    // count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(afq_pkg::DEPTH))
        else $error("entry count above depth");

    // a dequeue in progress never finds a pending result
    a_deq_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == afq_pkg::S_DEQ) |-> !r_out_valid)
        else $error("result pending during dequeue scan");

    // a flush leaves the queue empty
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_mode == afq_pkg::MODE_FLUSH)) |=> (r_count == '0))
        else $error("flush left entries");

    // each scan cycle that drops an entry lowers the count by one
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == afq_pkg::S_DEQ) && (r_count != '0) && (w_age >= r_max_delay))
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("drop did not lower count");

endmodule
